[design/bmhq_pkg.sv]
// Package for the binary min-heap queue: shared codes, state, command and status flag types.
// Used by bmhq_ctrl, bmhq_datapath and binary_min_heap_queue_core; no dependencies.
`default_nettype none

package bmhq_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Operation kinds on the input channel
  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EX_LOAD,
    S_UP_READ,
    S_UP_CMP,
    S_DN_READ,
    S_DN_CMP,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START_INS,
    OP_START_EXT,
    OP_REJECT_FULL,
    OP_REJECT_EMPTY,
    OP_LOAD_EXT,
    OP_UP_READ,
    OP_UP_MOVE,
    OP_DN_READ,
    OP_DN_MOVE,
    OP_PLACE,
    OP_EMIT
  } op_t;

  // Status flags from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic no_child;
    logic parent_gt;
    logic child_lt;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[design/binary_min_heap_queue_core.sv]
// Binary min-heap priority queue: usage notes.
// Input channel s_*: one item per operation. s_tuser is the kind (insert or
// extract), s_tdata the signed value to insert (ignored on extract).
// Output channel m_*: one item per input item, carrying the extracted minimum
// (zero unless a successful extract), a status (ok, empty, full) and the
// entry count after the operation.
// Items are handled one at a time. The heap sits in a memory with one write
// and two registered read ports; the hole walks one level per read and
// compare state pair. An insert climbs until the value reaches the root or
// its parent is not greater; an extract puts the last entry at the root and
// sinks it until it has no child or no smaller child. A rejected operation
// goes straight to the result; the next item is taken after the emit.
// The result sits in an output register, so the next item is taken while it
// waits; if m_tready stays low, the following result is held back and the
// input stalls until the register frees.
// Reset empties the queue at once and drops any waiting result; no clearing
// pass is needed since only held entries are ever used.
`default_nettype none

module binary_min_heap_queue_core import bmhq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [VALUE_W-1:0]       s_tdata,   // [31:0] value
  input  wire logic [0:0]               s_tuser,   // [0] kind
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // [31:0] min_value, then status (2 bits), then count, zero padded to bytes
  output logic [((VALUE_W+STATUS_W+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int TD_W = ((VALUE_W + STATUS_W + CW + 7) / 8) * 8;

  op_t                       op;
  stat_t                     stat;
  logic signed [VALUE_W-1:0] out_min;
  logic [STATUS_W-1:0]       out_status;
  logic [CW-1:0]             out_count;

  bmhq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser[0]),
    .in_ready (s_tready),
    .stat     (stat),
    .op       (op)
  );

  bmhq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .in_value   ($signed(s_tdata)),
    .stat       (stat),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_min    (out_min),
    .out_status (out_status),
    .out_count  (out_count)
  );

  // Pack the result item, lowest field first
  assign m_tdata = TD_W'({out_count, out_status, out_min});

endmodule

`default_nettype wire

[design/bmhq_datapath.sv]
// Datapath of the heap queue: heap memory, moving value, position, count and result register.
// Depends on bmhq_pkg; driven by commands from bmhq_ctrl.
`default_nettype none

module bmhq_datapath import bmhq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire op_t                           op,
  input  wire logic signed [VALUE_W-1:0]     in_value,
  output stat_t                              stat,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic signed [VALUE_W-1:0]          out_min,
  output logic [STATUS_W-1:0]                out_status,
  output logic [$clog2(CAPACITY+1)-1:0]      out_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  logic signed [VALUE_W-1:0] mem [CAPACITY];
  logic signed [VALUE_W-1:0] rd_a;
  logic signed [VALUE_W-1:0] rd_b;
  logic signed [VALUE_W-1:0] val;
  logic [AW-1:0]             pos;
  logic [CW-1:0]             cnt;
  logic signed [VALUE_W-1:0] res_min;
  logic [STATUS_W-1:0]       res_st;

  logic [IW-1:0]             lc;
  logic [IW-1:0]             rc;
  logic [IW-1:0]             n_ext;
  logic [AW-1:0]             parent;
  logic                      rc_out;
  logic                      pick_right;
  logic signed [VALUE_W-1:0] pick_val;
  logic [AW-1:0]             pick_idx;
  logic [AW-1:0]             ra;
  logic [AW-1:0]             rb;

  // Child and parent positions of the hole
  assign lc         = IW'({pos, 1'b1});
  assign rc         = lc + IW'(1);
  assign n_ext      = IW'(cnt);
  assign parent     = AW'((pos - AW'(1)) >> 1);
  assign rc_out     = (rc >= n_ext);
  // Right child wins on a tie
  assign pick_right = !rc_out && !(rd_a < rd_b);
  assign pick_val   = pick_right ? rd_b : rd_a;
  assign pick_idx   = pick_right ? AW'(rc) : AW'(lc);

  // Flags for the controller
  always_comb begin
    stat.full      = (cnt == CW'(CAPACITY));
    stat.empty     = (cnt == '0);
    stat.at_root   = (pos == '0);
    stat.no_child  = (lc >= n_ext);
    stat.parent_gt = (rd_a > val);
    stat.child_lt  = (val > pick_val);
    stat.out_free  = !out_valid || out_ready;
  end

  // Read addresses per command
  always_comb begin
    ra = '0;
    rb = '0;
    case (op)
      OP_START_EXT: begin
        rb = AW'(cnt - CW'(1));
      end
      OP_UP_READ: begin
        ra = parent;
      end
      OP_DN_READ: begin
        ra = AW'(lc);
        rb = AW'(rc);
      end
      default: begin
      end
    endcase
  end

  // Heap memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    rd_a <= mem[ra];
    rd_b <= mem[rb];
    case (op)
      OP_PLACE:   mem[pos] <= val;
      OP_UP_MOVE: mem[pos] <= rd_a;
      OP_DN_MOVE: mem[pos] <= pick_val;
      default: begin
      end
    endcase
  end

  // Moving value, hole position and result fields
  always_ff @(posedge clk) begin
    case (op)
      OP_START_INS: begin
        val     <= in_value;
        pos     <= AW'(cnt);
        res_min <= '0;
        res_st  <= ST_OK;
      end
      OP_REJECT_FULL: begin
        res_min <= '0;
        res_st  <= ST_FULL;
      end
      OP_REJECT_EMPTY: begin
        res_min <= '0;
        res_st  <= ST_EMPTY;
      end
      OP_LOAD_EXT: begin
        res_min <= rd_a;
        val     <= rd_b;
        pos     <= '0;
        res_st  <= ST_OK;
      end
      OP_UP_MOVE: pos <= parent;
      OP_DN_MOVE: pos <= pick_idx;
      default: begin
      end
    endcase
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (op == OP_START_INS) begin
      cnt <= cnt + CW'(1);
    end else if (op == OP_LOAD_EXT) begin
      cnt <= cnt - CW'(1);
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      out_min    <= res_min;
      out_status <= res_st;
      out_count  <= cnt;
    end
  end

endmodule

`default_nettype wire

[design/bmhq_ctrl.sv]
// Controller of the heap queue: sequences insert sift-up, extract sift-down, rejects and the result hand-off.
// Depends on bmhq_pkg; commands bmhq_datapath.
`default_nettype none

module bmhq_ctrl import bmhq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_kind,
  output logic       in_ready,
  input  wire stat_t stat,
  output op_t        op
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_INSERT) begin
            state_next = stat.full ? S_DONE : S_UP_READ;
          end else begin
            state_next = stat.empty ? S_DONE : S_EX_LOAD;
          end
        end
      end
      S_EX_LOAD: state_next = S_DN_READ;
      S_UP_READ: state_next = stat.at_root ? S_DONE : S_UP_CMP;
      S_UP_CMP:  state_next = stat.parent_gt ? S_UP_READ : S_DONE;
      S_DN_READ: state_next = stat.no_child ? S_DONE : S_DN_CMP;
      S_DN_CMP:  state_next = stat.child_lt ? S_DN_READ : S_DONE;
      S_DONE:    state_next = stat.out_free ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_INSERT) begin
            op = stat.full ? OP_REJECT_FULL : OP_START_INS;
          end else begin
            op = stat.empty ? OP_REJECT_EMPTY : OP_START_EXT;
          end
        end
      end
      S_EX_LOAD: op = OP_LOAD_EXT;
      S_UP_READ: op = stat.at_root ? OP_PLACE : OP_UP_READ;
      S_UP_CMP:  op = stat.parent_gt ? OP_UP_MOVE : OP_PLACE;
      S_DN_READ: op = stat.no_child ? OP_PLACE : OP_DN_READ;
      S_DN_CMP:  op = stat.child_lt ? OP_DN_MOVE : OP_PLACE;
      S_DONE:    op = stat.out_free ? OP_EMIT : OP_NONE;
      default:   op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire
